// File: rtl/one_wire_bus_master_core_assert.svh
// Assertion macros used by the checker file of the 1-Wire master.
`ifndef ONE_WIRE_BUS_MASTER_CORE_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OWB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OWB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types, codes and helpers of the 1-Wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owb_pkg;

    localparam int DEF_TICK_COUNT_BITS = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int BYTE_REG_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;

    // Register defaults before clamping.
    localparam logic [15:0] RST_RESET_LOW     = 16'd456;
    localparam logic [15:0] RST_PRESENCE_WAIT = 16'd66;
    localparam logic [15:0] RST_RESET_TAIL    = 16'd389;
    localparam logic [15:0] RST_SHORT_LOW     = 16'd6;
    localparam logic [15:0] RST_LONG_LOW      = 16'd60;
    localparam logic [15:0] RST_SLOT          = 16'd70;
    localparam logic [15:0] RST_READ_SAMPLE   = 16'd15;

    // Commands.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Reset status codes.
    localparam logic [1:0] ST_PRESENT   = 2'd0;
    localparam logic [1:0] ST_NO_DEVICE = 2'd1;
    localparam logic [1:0] ST_FAULT     = 2'd2;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic [1:0] reset_status;
    } t_owb_res;

    // A zero duration acts as one tick, and a duration never exceeds the
    // largest value the tick counter can reach.
    function automatic logic [15:0] dur_clamp(input logic [15:0] v, input logic [15:0] lim);
        logic [15:0] r;
        begin
            r = (v == 16'd0) ? 16'd1 : v;
            dur_clamp = (r > lim) ? lim : r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/owb_req_if.sv
// ----------------------------------------------------------------------------
// owb_req_if
// Tick channel into the 1-Wire master: command, byte to send, bus level.
// ----------------------------------------------------------------------------
`default_nettype none

interface owb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic       bus_level;

    modport source (output valid, output cmd, output tx_byte, output bus_level, input ready);
    modport sink   (input valid, input cmd, input tx_byte, input bus_level, output ready);
endinterface

`default_nettype wire

// File: rtl/owb_rsp_if.sv
// ----------------------------------------------------------------------------
// owb_rsp_if
// Result channel out of the 1-Wire master, one transfer per tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface owb_rsp_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] reset_status;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output rx_byte, output reset_status, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input rx_byte, input reset_status, output ready);
endinterface

`default_nettype wire

// File: rtl/owb_cfg.sv
// ----------------------------------------------------------------------------
// owb_cfg
// Timing register file; values are stored already clamped to the counter.
// ----------------------------------------------------------------------------
`default_nettype none

module owb_cfg #(
    parameter int TICK_COUNT_BITS = owb_pkg::DEF_TICK_COUNT_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [owb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [owb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [TICK_COUNT_BITS-1:0]        o_reset_low,
    output logic [TICK_COUNT_BITS-1:0]        o_presence_wait,
    output logic [TICK_COUNT_BITS-1:0]        o_reset_tail,
    output logic [TICK_COUNT_BITS-1:0]        o_short_low,
    output logic [TICK_COUNT_BITS-1:0]        o_long_low,
    output logic [TICK_COUNT_BITS-1:0]        o_slot,
    output logic [TICK_COUNT_BITS-1:0]        o_read_sample
);

    localparam logic [15:0] Lim16 = 16'((1 << TICK_COUNT_BITS) - 1);

    localparam logic [15:0] RstLow  = owb_pkg::dur_clamp(owb_pkg::RST_RESET_LOW, Lim16);
    localparam logic [15:0] RstWait = owb_pkg::dur_clamp(owb_pkg::RST_PRESENCE_WAIT, Lim16);
    localparam logic [15:0] RstTail = owb_pkg::dur_clamp(owb_pkg::RST_RESET_TAIL, Lim16);
    localparam logic [15:0] RstShrt = owb_pkg::dur_clamp(owb_pkg::RST_SHORT_LOW, Lim16);
    localparam logic [15:0] RstLong = owb_pkg::dur_clamp(owb_pkg::RST_LONG_LOW, Lim16);
    localparam logic [15:0] RstSlot = owb_pkg::dur_clamp(owb_pkg::RST_SLOT, Lim16);
    localparam logic [15:0] RstSamp = owb_pkg::dur_clamp(owb_pkg::RST_READ_SAMPLE, Lim16);

    logic [15:0] n_wide;
    logic [15:0] n_narrow;

    logic [TICK_COUNT_BITS-1:0] r_reset_low;
    logic [TICK_COUNT_BITS-1:0] r_presence_wait;
    logic [TICK_COUNT_BITS-1:0] r_reset_tail;
    logic [TICK_COUNT_BITS-1:0] r_short_low;
    logic [TICK_COUNT_BITS-1:0] r_long_low;
    logic [TICK_COUNT_BITS-1:0] r_slot;
    logic [TICK_COUNT_BITS-1:0] r_read_sample;

    // The reset-low and reset-tail registers take the whole data word, the others its low byte.
    assign n_wide   = owb_pkg::dur_clamp(
                          {{(16 - owb_pkg::CFG_DATA_W){1'b0}}, i_cfg_data}, Lim16);
    assign n_narrow = owb_pkg::dur_clamp(
                          {{(16 - owb_pkg::BYTE_REG_W){1'b0}},
                           i_cfg_data[owb_pkg::BYTE_REG_W-1:0]}, Lim16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low     <= RstLow[TICK_COUNT_BITS-1:0];
            r_presence_wait <= RstWait[TICK_COUNT_BITS-1:0];
            r_reset_tail    <= RstTail[TICK_COUNT_BITS-1:0];
            r_short_low     <= RstShrt[TICK_COUNT_BITS-1:0];
            r_long_low      <= RstLong[TICK_COUNT_BITS-1:0];
            r_slot          <= RstSlot[TICK_COUNT_BITS-1:0];
            r_read_sample   <= RstSamp[TICK_COUNT_BITS-1:0];
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                owb_pkg::REG_RESET_LOW:     r_reset_low     <= n_wide[TICK_COUNT_BITS-1:0];
                owb_pkg::REG_PRESENCE_WAIT: r_presence_wait <= n_narrow[TICK_COUNT_BITS-1:0];
                owb_pkg::REG_RESET_TAIL:    r_reset_tail    <= n_wide[TICK_COUNT_BITS-1:0];
                owb_pkg::REG_SHORT_LOW:     r_short_low     <= n_narrow[TICK_COUNT_BITS-1:0];
                owb_pkg::REG_LONG_LOW:      r_long_low      <= n_narrow[TICK_COUNT_BITS-1:0];
                owb_pkg::REG_SLOT:          r_slot          <= n_narrow[TICK_COUNT_BITS-1:0];
                owb_pkg::REG_READ_SAMPLE:   r_read_sample   <= n_narrow[TICK_COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_reset_low     = r_reset_low;
    assign o_presence_wait = r_presence_wait;
    assign o_reset_tail    = r_reset_tail;
    assign o_short_low     = r_short_low;
    assign o_long_low      = r_long_low;
    assign o_slot          = r_slot;
    assign o_read_sample   = r_read_sample;

endmodule

`default_nettype wire

// File: rtl/owb_seq.sv
// ----------------------------------------------------------------------------
// owb_seq
// Bus sequencer: advances reset, write and read phases by one tick per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module owb_seq #(
    parameter int TICK_COUNT_BITS = owb_pkg::DEF_TICK_COUNT_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_fire,
    input  wire  [1:0]                   i_cmd,
    input  wire  [7:0]                   i_tx_byte,
    input  wire                          i_bus_level,
    input  wire  [TICK_COUNT_BITS-1:0]   i_reset_low,
    input  wire  [TICK_COUNT_BITS-1:0]   i_presence_wait,
    input  wire  [TICK_COUNT_BITS-1:0]   i_reset_tail,
    input  wire  [TICK_COUNT_BITS-1:0]   i_short_low,
    input  wire  [TICK_COUNT_BITS-1:0]   i_long_low,
    input  wire  [TICK_COUNT_BITS-1:0]   i_slot,
    input  wire  [TICK_COUNT_BITS-1:0]   i_read_sample,
    output owb_pkg::t_owb_res            o_res
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_RLOW  = 3'd1;
    localparam logic [2:0] PH_RWAIT = 3'd2;
    localparam logic [2:0] PH_RTAIL = 3'd3;
    localparam logic [2:0] PH_WSLOT = 3'd4;
    localparam logic [2:0] PH_RSLOT = 3'd5;

    localparam logic [TICK_COUNT_BITS-1:0] CountMax = '1;

    logic [2:0]                 r_phase,  n_phase;
    logic [TICK_COUNT_BITS-1:0] r_tick,   n_tick;
    logic [2:0]                 r_bit,    n_bit;
    logic [7:0]                 r_shift,  n_shift;
    logic                       r_pres,   n_pres;
    logic [1:0]                 r_status, n_status;
    logic [7:0]                 r_rx,     n_rx;

    logic                       drive;
    logic                       done;
    logic                       rd;
    logic [TICK_COUNT_BITS-1:0] cnt;
    logic [TICK_COUNT_BITS-1:0] low;
    logic [TICK_COUNT_BITS-1:0] samp;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_pres   = r_pres;
        n_status = r_status;
        n_rx     = r_rx;
        drive    = 1'b0;
        done     = 1'b0;
        rd       = 1'b0;
        cnt      = '0;
        low      = '0;
        samp     = '0;
        if (i_fire) begin
            // A command starts on the tick that carries it; while busy it is dropped.
            if (r_phase == PH_IDLE) begin
                case (i_cmd)
                    owb_pkg::CMD_RESET: begin
                        if (!i_bus_level) begin
                            n_status = owb_pkg::ST_FAULT;
                            done     = 1'b1;
                        end else begin
                            n_phase = PH_RLOW;
                            n_tick  = '0;
                        end
                    end
                    owb_pkg::CMD_WRITE, owb_pkg::CMD_READ: begin
                        n_phase = (i_cmd == owb_pkg::CMD_WRITE) ? PH_WSLOT : PH_RSLOT;
                        n_tick  = '0;
                        n_bit   = 3'd0;
                        n_shift = (i_cmd == owb_pkg::CMD_WRITE) ? i_tx_byte : 8'h00;
                    end
                    default: begin
                    end
                endcase
            end

            // Saturating tick count after this tick.
            cnt = (n_tick == CountMax) ? n_tick : n_tick + 1'b1;

            case (n_phase)
                PH_IDLE: begin
                end
                PH_RLOW: begin
                    drive  = 1'b1;
                    n_tick = cnt;
                    if (cnt >= i_reset_low) begin
                        n_phase = PH_RWAIT;
                        n_tick  = '0;
                    end
                end
                PH_RWAIT: begin
                    n_tick = cnt;
                    if (cnt >= i_presence_wait) begin
                        n_pres  = i_bus_level;
                        n_phase = PH_RTAIL;
                        n_tick  = '0;
                    end
                end
                PH_RTAIL: begin
                    n_tick = cnt;
                    if (cnt >= i_reset_tail) begin
                        if (!i_bus_level) begin
                            n_status = owb_pkg::ST_FAULT;
                        end else if (r_pres) begin
                            n_status = owb_pkg::ST_NO_DEVICE;
                        end else begin
                            n_status = owb_pkg::ST_PRESENT;
                        end
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        done    = 1'b1;
                    end
                end
                PH_WSLOT, PH_RSLOT: begin
                    rd    = (n_phase == PH_RSLOT);
                    low   = (rd || n_shift[0]) ? i_short_low : i_long_low;
                    samp  = (i_read_sample > i_slot) ? i_slot : i_read_sample;
                    drive = (n_tick < low);
                    n_tick = cnt;
                    if (rd && (cnt == samp)) begin
                        n_shift = {i_bus_level, n_shift[7:1]};
                    end
                    if (cnt >= i_slot) begin
                        if (!rd) begin
                            n_shift = {1'b0, n_shift[7:1]};
                        end
                        n_tick = '0;
                        if (n_bit == 3'd7) begin
                            if (rd) begin
                                n_rx = n_shift;
                            end
                            n_bit   = 3'd0;
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_bit = n_bit + 3'd1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_bit    <= 3'd0;
            r_shift  <= 8'h00;
            r_pres   <= 1'b1;
            r_status <= owb_pkg::ST_PRESENT;
            r_rx     <= 8'h00;
        end else begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_pres   <= n_pres;
            r_status <= n_status;
            r_rx     <= n_rx;
        end
    end

    assign o_res.drive_low    = drive;
    assign o_res.busy_res     = (n_phase != PH_IDLE);
    assign o_res.done_res     = done;
    assign o_res.rx_byte      = n_rx;
    assign o_res.reset_status = n_status;

endmodule

`default_nettype wire

// File: rtl/one_wire_bus_master_core.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_core: standard-speed 1-Wire master, one tick per transfer.
// Output is registered; the result register loads at the transfer of its tick.
// Throughput: one tick per cycle; a waiting result holds off ticks until it is taken.
// Reset clears the sequencer to idle and loads the default timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_core #(
    parameter int TICK_COUNT_BITS = owb_pkg::DEF_TICK_COUNT_BITS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    owb_req_if.sink                         i_req,
    owb_rsp_if.source                       o_rsp,
    input  wire                             i_cfg_we,
    input  wire  [owb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [owb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [TICK_COUNT_BITS-1:0] reset_low;
    logic [TICK_COUNT_BITS-1:0] presence_wait;
    logic [TICK_COUNT_BITS-1:0] reset_tail;
    logic [TICK_COUNT_BITS-1:0] short_low;
    logic [TICK_COUNT_BITS-1:0] long_low;
    logic [TICK_COUNT_BITS-1:0] slot;
    logic [TICK_COUNT_BITS-1:0] read_sample;

    owb_pkg::t_owb_res res;
    owb_pkg::t_owb_res r_out;
    logic              r_out_valid;
    logic              in_ready;
    logic              fire;

    assign in_ready    = !r_out_valid || o_rsp.ready;
    assign fire        = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    owb_cfg #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_reset_low     (reset_low),
        .o_presence_wait (presence_wait),
        .o_reset_tail    (reset_tail),
        .o_short_low     (short_low),
        .o_long_low      (long_low),
        .o_slot          (slot),
        .o_read_sample   (read_sample)
    );

    owb_seq #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_cmd           (i_req.cmd),
        .i_tx_byte       (i_req.tx_byte),
        .i_bus_level     (i_req.bus_level),
        .i_reset_low     (reset_low),
        .i_presence_wait (presence_wait),
        .i_reset_tail    (reset_tail),
        .i_short_low     (short_low),
        .i_long_low      (long_low),
        .i_slot          (slot),
        .i_read_sample   (read_sample),
        .o_res           (res)
    );

    // Result register: loaded on every tick transfer, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.drive_low    = r_out.drive_low;
    assign o_rsp.busy_res     = r_out.busy_res;
    assign o_rsp.done_res     = r_out.done_res;
    assign o_rsp.rx_byte      = r_out.rx_byte;
    assign o_rsp.reset_status = r_out.reset_status;

endmodule

`default_nettype wire

// File: rtl/owb_chk.sv
// ----------------------------------------------------------------------------
// owb_chk
// Port-level checks of the 1-Wire master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "one_wire_bus_master_core_assert.svh"

module owb_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_drive_low,
    input wire       i_busy,
    input wire       i_done,
    input wire [7:0] i_rx,
    input wire [1:0] i_status
);

    // Every tick transfer yields a result in the next cycle.
    `OWB_ASSERT_NEXT(a_tick_gives_result, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "tick transfer produced no result")

    // A command that completes leaves the master idle.
    `OWB_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, i_out_valid && i_done, !i_busy, "done reported while still busy")

    `OWB_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_out_valid, (i_status == owb_pkg::ST_PRESENT) || (i_status == owb_pkg::ST_NO_DEVICE) || (i_status == owb_pkg::ST_FAULT), "undefined reset status")

    `OWB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_drive_low) && $stable(i_busy) && $stable(i_done) && $stable(i_rx) && $stable(i_status), "stalled result changed")

endmodule

bind one_wire_bus_master_core owb_chk u_owb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_drive_low (o_rsp.drive_low),
    .i_busy      (o_rsp.busy_res),
    .i_done      (o_rsp.done_res),
    .i_rx        (o_rsp.rx_byte),
    .i_status    (o_rsp.reset_status)
);

`default_nettype wire
